// ===== hdl/ldwbc_pkg.sv =====
// ----------------------------------------------------------------------------
// ldwbc_pkg
// Shared constants, codes and types of the lane delay-window and bitslip
// calibration block.
// ----------------------------------------------------------------------------
package ldwbc_pkg;

    localparam int TAP_COUNT   = 32;
    localparam int TAP_W       = 5;
    localparam int CNT_W       = 6;
    localparam int SUM_W       = 9;
    localparam int SLIP_W      = 3;
    localparam int TRY_W       = 4;
    localparam int MAX_TRIES   = 8;
    localparam int DIV_CW      = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 32;
    localparam int WORD_W      = 32;

    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_COUNT - 1);

    typedef enum logic [CFG_AW-1:0] {
        REG_PATTERN    = 2'd0,
        REG_MIN_WINDOW = 2'd1,
        REG_FALLBACK   = 2'd2,
        REG_SLIP_TRIES = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_SLIP   = 2'd1,
        CMD_REPORT = 2'd2
    } cmd_t;

    typedef struct packed {
        logic start;
        logic hit;
        logic exact;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] pattern;
        logic [CNT_W-1:0]  min_window_len;
        logic [TAP_W-1:0]  fallback_tap;
        logic [TRY_W-1:0]  slip_tries;
    } cfg_t;

    typedef struct packed {
        cmd_t              command;
        logic [TAP_W-1:0]  delay_tap;
        logic [SLIP_W-1:0] slip_count;
        logic              aligned;
        logic              last;
    } result_t;

endpackage

// ===== hdl/lane_delay_window_bitslip_calibration.sv =====
// ----------------------------------------------------------------------------
// lane_delay_window_bitslip_calibration
// Delay-window scan and bitslip training for one serial lane.
// ----------------------------------------------------------------------------
// A start beat (tuser 0) commands tap 0; each word beat (tuser 1) then
// steps the scan or the bitslip search and yields one or two result beats,
// or none outside a scan or search. Input beats pass through a two-entry
// queue, so the input side keeps accepting while a result waits, until the
// queue is full. The beat that ends the scan passes through the nine-step
// serial divider that finds the center tap; a beat that yields two results
// sends the second from a separate state after the first.
module lane_delay_window_bitslip_calibration
    import ldwbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,   // test_word
    input  logic              s_tuser,   // operation
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // delay_tap, slip_count, aligned, zero pad
    output logic [1:0]        m_tuser,   // command
    output logic              m_tlast
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    full;
    logic    push;
    item_t   push_item;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_PATTERN:    cfg_next.pattern        = cfg_data;
                REG_MIN_WINDOW: cfg_next.min_window_len = cfg_data[CNT_W-1:0];
                REG_FALLBACK:   cfg_next.fallback_tap   = cfg_data[TAP_W-1:0];
                REG_SLIP_TRIES: cfg_next.slip_tries     = cfg_data[TRY_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern        <= 32'hFFAA5500;
            cfg_reg.min_window_len <= CNT_W'(5);
            cfg_reg.fallback_tap   <= TAP_W'(9);
            cfg_reg.slip_tries     <= TRY_W'(4);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ldwbc_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .pattern   (cfg_reg.pattern),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    ldwbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop_valid (q_valid),
        .pop_item  (q_item),
        .pop       (q_pop)
    );

    ldwbc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .min_window_len (cfg_reg.min_window_len),
        .fallback_tap   (cfg_reg.fallback_tap),
        .slip_tries     (cfg_reg.slip_tries),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_result     (result)
    );

    assign m_tdata = {7'b0, result.aligned, result.slip_count, result.delay_tap};
    assign m_tuser = result.command;
    assign m_tlast = result.last;

endmodule

// ===== hdl/ldwbc_front.sv =====
// ----------------------------------------------------------------------------
// ldwbc_front
// Accepts input beats and classifies each test word against the training
// pattern and its byte rotations.
// ----------------------------------------------------------------------------
module ldwbc_front
    import ldwbc_pkg::*;
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,
    input  logic              s_tuser,
    input  logic [WORD_W-1:0] pattern,
    input  logic              full,
    output logic              push,
    output item_t             push_item
);

    logic [WORD_W-1:0] rot8;
    logic [WORD_W-1:0] rot16;
    logic [WORD_W-1:0] rot24;

    assign rot8  = {pattern[7:0],  pattern[WORD_W-1:8]};
    assign rot16 = {pattern[15:0], pattern[WORD_W-1:16]};
    assign rot24 = {pattern[23:0], pattern[WORD_W-1:24]};

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    always_comb
    begin
        push_item.start = !s_tuser;
        push_item.exact = (s_tdata == pattern);
        push_item.hit   = (s_tdata == pattern) || (s_tdata == rot8) ||
                          (s_tdata == rot16) || (s_tdata == rot24);
    end

endmodule

// ===== hdl/ldwbc_queue.sv =====
// ----------------------------------------------------------------------------
// ldwbc_queue
// Short queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module ldwbc_queue
    import ldwbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output logic  pop_valid,
    output item_t pop_item,
    input  logic  pop
);

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/ldwbc_back.sv =====
// ----------------------------------------------------------------------------
// ldwbc_back
// Runs the delay scan and bitslip search, finds the center tap with a
// serial divider and holds each result in an output register.
// ----------------------------------------------------------------------------
module ldwbc_back
    import ldwbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] min_window_len,
    input  logic [TAP_W-1:0] fallback_tap,
    input  logic [TRY_W-1:0] slip_tries,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output result_t          out_result
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIV    = 4'b0010,
        ST_CENTRE = 4'b0100,
        ST_SECOND = 4'b1000
    } back_state_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_SCAN = 4'b0010,
        PH_SLIP = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    back_state_t       state_reg;
    back_state_t       state_next;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [TAP_W-1:0]  tap_reg;
    logic [TAP_W-1:0]  tap_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              locked_reg;
    logic              locked_next;
    logic [TAP_W-1:0]  chosen_reg;
    logic [TAP_W-1:0]  chosen_next;
    logic [SLIP_W-1:0] slip_reg;
    logic [SLIP_W-1:0] slip_next;
    logic [DIV_CW-1:0] div_cnt_reg;
    logic [DIV_CW-1:0] div_cnt_next;
    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  quo_next;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W:0]    rem_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_res_reg;
    result_t           out_res_next;

    logic              out_free;
    logic              load;
    result_t           res;
    logic [TRY_W-1:0]  tries_lim;
    logic [CNT_W-1:0]  cnt_inc;
    logic [TRY_W-1:0]  slip_inc;
    logic              stop;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W+1:0]  trial;

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_res_reg;
    assign tries_lim  = (slip_tries > TRY_W'(MAX_TRIES)) ? TRY_W'(MAX_TRIES) : slip_tries;
    assign cnt_inc    = cnt_reg + 1'b1;
    assign slip_inc   = {1'b0, slip_reg} + 1'b1;
    assign rem_shift  = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign trial      = {1'b0, rem_shift} - {2'b00, cnt_reg};

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        tap_next     = tap_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        locked_next  = locked_reg;
        chosen_next  = chosen_reg;
        slip_next    = slip_reg;
        div_cnt_next = div_cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        q_pop        = 1'b0;
        load         = 1'b0;
        stop         = 1'b0;
        res          = '0;
        res.command  = CMD_SET;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_item.start)
                    begin
                        phase_next  = PH_SCAN;
                        tap_next    = '0;
                        cnt_next    = '0;
                        sum_next    = '0;
                        locked_next = 1'b0;
                        chosen_next = '0;
                        slip_next   = '0;
                        load        = 1'b1;
                        res.last    = 1'b1;
                    end
                    else if (phase_reg == PH_SCAN)
                    begin
                        if (q_item.hit)
                        begin
                            cnt_next = cnt_inc;
                            sum_next = sum_reg + SUM_W'(tap_reg);
                            if (cnt_inc >= min_window_len)
                            begin
                                locked_next = 1'b1;
                            end
                        end
                        else if (locked_reg)
                        begin
                            stop = 1'b1;
                        end
                        else
                        begin
                            cnt_next = '0;
                            sum_next = '0;
                        end
                        if (!stop && tap_reg != TAP_LAST)
                        begin
                            tap_next      = tap_reg + 1'b1;
                            load          = 1'b1;
                            res.delay_tap = tap_reg + 1'b1;
                            res.last      = 1'b1;
                        end
                        else
                        begin
                            state_next   = ST_DIV;
                            div_cnt_next = DIV_CW'(SUM_W);
                            quo_next     = sum_next;
                            rem_next     = '0;
                        end
                    end
                    else if (phase_reg == PH_SLIP)
                    begin
                        load          = 1'b1;
                        res.delay_tap = chosen_reg;
                        if (q_item.exact)
                        begin
                            phase_next     = PH_DONE;
                            res.command    = CMD_REPORT;
                            res.slip_count = slip_reg;
                            res.aligned    = 1'b1;
                            res.last       = 1'b1;
                        end
                        else
                        begin
                            slip_next   = slip_inc[SLIP_W-1:0];
                            res.command = CMD_SLIP;
                            if (slip_inc >= tries_lim)
                            begin
                                phase_next = PH_DONE;
                                state_next = ST_SECOND;
                            end
                            else
                            begin
                                res.last = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (trial[CNT_W+1])
                begin
                    rem_next = rem_shift;
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = trial[CNT_W:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == DIV_CW'(1))
                begin
                    state_next = ST_CENTRE;
                end
            end
            ST_CENTRE:
            begin
                if (out_free)
                begin
                    chosen_next   = (cnt_reg != '0) ? quo_reg[TAP_W-1:0] : fallback_tap;
                    slip_next     = '0;
                    load          = 1'b1;
                    res.delay_tap = chosen_next;
                    if (tries_lim == '0)
                    begin
                        phase_next = PH_DONE;
                        state_next = ST_SECOND;
                    end
                    else
                    begin
                        phase_next = PH_SLIP;
                        state_next = ST_IDLE;
                        res.last   = 1'b1;
                    end
                end
            end
            ST_SECOND:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    res.command   = CMD_REPORT;
                    res.delay_tap = chosen_reg;
                    res.last      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            tap_reg       <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            locked_reg    <= 1'b0;
            chosen_reg    <= '0;
            slip_reg      <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            tap_reg       <= tap_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            locked_reg    <= locked_next;
            chosen_reg    <= chosen_next;
            slip_reg      <= slip_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        out_res_reg <= out_res_next;
    end

`ifndef NO_ASSERTIONS
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |=> state_reg == ST_DIV || state_reg == ST_CENTRE)
        else $error("divider left for an unexpected state");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TAP_COUNT))
        else $error("run count above tap count");

    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.command == CMD_REPORT |-> out_res_reg.last)
        else $error("report beat without last");

    a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SECOND |-> out_valid_reg && !out_res_reg.last)
        else $error("second result without a pending first beat");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE && out_free)
        else $error("queue popped while busy");
`endif

endmodule
